### rtl/core/power_law_capillary_pressure_assert.svh
// assertion macros shared by the capillary pressure rtl
// both sample on clk and stay quiet while rst_n is low
`ifndef POWER_LAW_CAPILLARY_PRESSURE_ASSERT_SVH
`define POWER_LAW_CAPILLARY_PRESSURE_ASSERT_SVH

// same-cycle implication
`define PLCP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plcp assertion failed");

// next-cycle implication
`define PLCP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plcp assertion failed");

`endif

### rtl/core/plcp_pkg.sv
`default_nettype none

package plcp_pkg;

    typedef struct packed {
        logic [15:0] saturation;
        logic [15:0] sat_min;
        logic [15:0] sat_max;
        logic [31:0] entry_pressure;
        logic [15:0] exponent;
    } cell_t;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK     = 2'd0;
    localparam status_t STATUS_AT_MIN = 2'd1;
    localparam status_t STATUS_EMPTY  = 2'd2;

    typedef struct packed {
        logic [31:0]        cap_pressure;
        logic signed [47:0] cap_pressure_slope;
        status_t            status;
    } result_t;

    // slope quotient bits below the saturation point, and divider steps per stage
    localparam int SLOPE_Q_W = 47;
    localparam int DIV_STEPS = 4;

    localparam logic [63:0] WIDE_CAP = 64'h4000_0000_0000_0000;

endpackage

`default_nettype wire

### rtl/core/plcp_div.sv
`default_nettype none

module plcp_div #(
    parameter int QW    = 47,
    parameter int DW    = 16,
    parameter int STEPS = 4
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire logic [DW-1:0] rem_in,
    input  wire logic [QW-1:0] num_in,
    input  wire logic [DW-1:0] den_in,
    output logic      [QW-1:0] quot
);

    localparam int NST = (QW + STEPS - 1) / STEPS;

    logic [DW-1:0] rem_src [0:NST];
    logic [QW-1:0] num_src [0:NST];
    logic [QW-1:0] q_src   [0:NST];
    logic [DW-1:0] den_src [0:NST];

    logic [DW-1:0] rem_reg [0:NST-1];
    logic [QW-1:0] num_reg [0:NST-1];
    logic [QW-1:0] q_reg   [0:NST-1];
    logic [DW-1:0] den_reg [0:NST-1];

    logic [DW-1:0] rem_next [0:NST-1];
    logic [QW-1:0] num_next [0:NST-1];
    logic [QW-1:0] q_next   [0:NST-1];

    assign rem_src[0] = rem_in;
    assign num_src[0] = num_in;
    assign q_src[0]   = '0;
    assign den_src[0] = den_in;

    for (genvar g = 0; g < NST; g++) begin : g_stage
        assign rem_src[g+1] = rem_reg[g];
        assign num_src[g+1] = num_reg[g];
        assign q_src[g+1]   = q_reg[g];
        assign den_src[g+1] = den_reg[g];

        // restoring steps, one quotient bit each
        always_comb
        begin
            logic [DW:0]   t;
            logic [DW-1:0] r;
            logic [QW-1:0] nm;
            logic [QW-1:0] q;
            r  = rem_src[g];
            nm = num_src[g];
            q  = q_src[g];
            t  = '0;
            for (int k = 0; k < STEPS; k++)
            begin
                if (g * STEPS + k < QW)
                begin
                    t  = {r, nm[QW-1]};
                    nm = {nm[QW-2:0], 1'b0};
                    if (t >= {1'b0, den_src[g]})
                    begin
                        r = DW'(t - {1'b0, den_src[g]});
                        q = {q[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        r = t[DW-1:0];
                        q = {q[QW-2:0], 1'b0};
                    end
                end
            end
            rem_next[g] = r;
            num_next[g] = nm;
            q_next[g]   = q;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= rem_next[g];
                num_reg[g] <= num_next[g];
                q_reg[g]   <= q_next[g];
                den_reg[g] <= den_src[g];
            end
        end
    end

    assign quot = q_reg[NST-1];

endmodule

`default_nettype wire

### rtl/core/power_law_capillary_pressure.sv
// stages from cell accept to result valid: 13 front stages, 12 divider stages, output
// throughput: one cell per cycle; the whole pipeline advances together and holds on a stall
// the slope divider retires up to 4 quotient bits per stage
// reset: rst_n async active low clears all valid bits; data registers are not reset
// the log2 and exp2 tables are constants built at elaboration, no fill time after reset
`default_nettype none

module power_law_capillary_pressure #(
    parameter int LOG_TABLE_BITS = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cell_valid,
    output logic                   cell_ready,
    input  wire plcp_pkg::cell_t   cell_data,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output plcp_pkg::result_t      result
);

`include "power_law_capillary_pressure_assert.svh"

    // table geometry
    localparam int TSIZE     = (1 << LOG_TABLE_BITS) + 1;
    localparam int IDX_W     = LOG_TABLE_BITS;
    localparam int LOG_REM_W = 15 - LOG_TABLE_BITS;  // mantissa bits below the log index
    localparam int EXP_REM_W = 16 - LOG_TABLE_BITS;  // fraction bits below the exp index
    localparam int NFRONT    = 13;
    localparam int DIV_ST    = (plcp_pkg::SLOPE_Q_W + plcp_pkg::DIV_STEPS - 1)
                               / plcp_pkg::DIV_STEPS;

    typedef logic [16:0] log_tab_t [0:TSIZE-1];
    typedef logic [31:0] exp_tab_t [0:TSIZE-1];

    // integer square root, used only while building the exp table
    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = x;
        res = '0;
        b   = 64'h4000_0000_0000_0000;
        while (b > v)
            b = b >> 2;
        while (b != 64'd0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // log2(1 + i/T) in q16, by repeated squaring of the q1.30 mantissa
    function automatic log_tab_t build_log();
        log_tab_t    t;
        logic [63:0] m;
        logic [16:0] v;
        for (int i = 0; i < TSIZE - 1; i++)
        begin
            m = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
            v = '0;
            for (int k = 0; k < 16; k++)
            begin
                m = (m * m) >> 30;
                v = {v[15:0], 1'b0};
                if (m >= (64'd1 << 31))
                begin
                    m    = m >> 1;
                    v[0] = 1'b1;
                end
            end
            t[i] = v;
            if (i > 0 && t[i] < t[i-1])
                t[i] = t[i-1];
        end
        t[TSIZE-1] = 17'h10000;
        return t;
    endfunction

    // 2^(i/T) in q1.30, products of successive roots of two
    function automatic exp_tab_t build_exp();
        exp_tab_t    t;
        logic [63:0] roots [0:12];
        logic [63:0] m;
        for (int k = 0; k < 13; k++)
            roots[k] = '0;
        roots[0] = 64'd2 << 30;
        roots[1] = isqrt64(64'd1 << 61);
        for (int k = 1; k < LOG_TABLE_BITS; k++)
            roots[k+1] = isqrt64(roots[k] << 30);
        for (int i = 0; i < TSIZE - 1; i++)
        begin
            m = 64'd1 << 30;
            for (int j = 0; j < LOG_TABLE_BITS; j++)
                if (((i >> j) & 1) != 0)
                    m = (m * roots[LOG_TABLE_BITS - j]) >> 30;
            t[i] = m[31:0];
            if (i > 0 && t[i] < t[i-1])
                t[i] = t[i-1];
        end
        t[TSIZE-1] = 32'h8000_0000;
        if (t[TSIZE-1] < t[TSIZE-2])
            t[TSIZE-1] = t[TSIZE-2];
        return t;
    endfunction

    localparam log_tab_t LOG_ROM = build_log();
    localparam exp_tab_t EXP_ROM = build_exp();

    // leading one position and table split of a 16 bit value
    typedef struct packed {
        logic [3:0]           p;
        logic [IDX_W-1:0]     idx;
        logic [LOG_REM_W-1:0] rem;
    } log_split_t;

    function automatic log_split_t split_log(input logic [15:0] x);
        log_split_t  s;
        logic [15:0] m;
        s.p = '0;
        for (int i = 0; i < 16; i++)
            if (x[i])
                s.p = 4'(i);
        m     = x << (4'd15 - s.p);
        s.idx = m[14 -: IDX_W];
        s.rem = m[LOG_REM_W-1:0];
        return s;
    endfunction

    // the pipeline moves as one; it stops only when a finished result is not taken
    logic en;
    assign en         = !result_valid || result_ready;
    assign cell_ready = en;

    logic [NFRONT-1:0] vld_reg;
    logic [DIV_ST-1:0] dly_vld_reg;
    logic              out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            dly_vld_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[NFRONT-2:0], cell_valid};
            dly_vld_reg <= {dly_vld_reg[DIV_ST-2:0], vld_reg[NFRONT-1]};
            out_vld_reg <= dly_vld_reg[DIV_ST-1];
        end
    end

    // stage 1: differences and special cases
    plcp_pkg::status_t s1_status_next, s1_status_reg;
    logic [15:0]       s1_d_next, s1_d_reg;
    logic [15:0]       s1_r_next, s1_r_reg;
    logic [31:0]       s1_pc0_reg;
    logic [15:0]       s1_n_reg;

    always_comb
    begin
        if (cell_data.saturation <= cell_data.sat_min)
            s1_status_next = plcp_pkg::STATUS_AT_MIN;
        else if (cell_data.sat_max <= cell_data.sat_min)
            s1_status_next = plcp_pkg::STATUS_EMPTY;
        else
            s1_status_next = plcp_pkg::STATUS_OK;
        s1_d_next = cell_data.saturation - cell_data.sat_min;
        s1_r_next = cell_data.sat_max - cell_data.sat_min;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_status_reg <= s1_status_next;
            s1_d_reg      <= s1_d_next;
            s1_r_reg      <= s1_r_next;
            s1_pc0_reg    <= cell_data.entry_pressure;
            s1_n_reg      <= cell_data.exponent;
        end
    end

    // stage 2: normalize d and r for the log tables
    log_split_t        s2_ld_next, s2_ld_reg;
    log_split_t        s2_lr_next, s2_lr_reg;
    plcp_pkg::status_t s2_status_reg;
    logic [15:0]       s2_d_reg;
    logic [31:0]       s2_pc0_reg;
    logic [15:0]       s2_n_reg;

    assign s2_ld_next = split_log(s1_d_reg);
    assign s2_lr_next = split_log(s1_r_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_ld_reg     <= s2_ld_next;
            s2_lr_reg     <= s2_lr_next;
            s2_status_reg <= s1_status_reg;
            s2_d_reg      <= s1_d_reg;
            s2_pc0_reg    <= s1_pc0_reg;
            s2_n_reg      <= s1_n_reg;
        end
    end

    // stage 3: log table reads, neighbor entries for interpolation
    logic [16:0]          s3_lod_next, s3_lod_reg, s3_dfd_next, s3_dfd_reg;
    logic [16:0]          s3_lor_next, s3_lor_reg, s3_dfr_next, s3_dfr_reg;
    logic [3:0]           s3_pd_reg, s3_pr_reg;
    logic [LOG_REM_W-1:0] s3_remd_reg, s3_remr_reg;
    plcp_pkg::status_t    s3_status_reg;
    logic [15:0]          s3_d_reg;
    logic [31:0]          s3_pc0_reg;
    logic [15:0]          s3_n_reg;

    always_comb
    begin
        s3_lod_next = LOG_ROM[{1'b0, s2_ld_reg.idx}];
        s3_dfd_next = LOG_ROM[(IDX_W+1)'(s2_ld_reg.idx) + 1'b1] - s3_lod_next;
        s3_lor_next = LOG_ROM[{1'b0, s2_lr_reg.idx}];
        s3_dfr_next = LOG_ROM[(IDX_W+1)'(s2_lr_reg.idx) + 1'b1] - s3_lor_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_lod_reg    <= s3_lod_next;
            s3_dfd_reg    <= s3_dfd_next;
            s3_lor_reg    <= s3_lor_next;
            s3_dfr_reg    <= s3_dfr_next;
            s3_pd_reg     <= s2_ld_reg.p;
            s3_pr_reg     <= s2_lr_reg.p;
            s3_remd_reg   <= s2_ld_reg.rem;
            s3_remr_reg   <= s2_lr_reg.rem;
            s3_status_reg <= s2_status_reg;
            s3_d_reg      <= s2_d_reg;
            s3_pc0_reg    <= s2_pc0_reg;
            s3_n_reg      <= s2_n_reg;
        end
    end

    // stage 4: interpolate, log2 in q16
    logic [17+LOG_REM_W-1:0] s4_prodd, s4_prodr;
    logic [20:0]             s4_logd_next, s4_logd_reg, s4_logr_next, s4_logr_reg;
    plcp_pkg::status_t       s4_status_reg;
    logic [15:0]             s4_d_reg;
    logic [31:0]             s4_pc0_reg;
    logic [15:0]             s4_n_reg;

    always_comb
    begin
        s4_prodd     = (17+LOG_REM_W)'(s3_dfd_reg) * (17+LOG_REM_W)'(s3_remd_reg);
        s4_prodr     = (17+LOG_REM_W)'(s3_dfr_reg) * (17+LOG_REM_W)'(s3_remr_reg);
        s4_logd_next = (21'(s3_pd_reg) << 16) + 21'(s3_lod_reg)
                       + 21'(s4_prodd >> LOG_REM_W);
        s4_logr_next = (21'(s3_pr_reg) << 16) + 21'(s3_lor_reg)
                       + 21'(s4_prodr >> LOG_REM_W);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_logd_reg   <= s4_logd_next;
            s4_logr_reg   <= s4_logr_next;
            s4_status_reg <= s3_status_reg;
            s4_d_reg      <= s3_d_reg;
            s4_pc0_reg    <= s3_pc0_reg;
            s4_n_reg      <= s3_n_reg;
        end
    end

    // stage 5: log of the normalized saturation, split into sign and magnitude
    logic signed [21:0] s5_l;
    logic [20:0]        s5_abs_next, s5_abs_reg;
    logic               s5_neg_reg;
    plcp_pkg::status_t  s5_status_reg;
    logic [15:0]        s5_d_reg;
    logic [31:0]        s5_pc0_reg;
    logic [15:0]        s5_n_reg;

    always_comb
    begin
        s5_l        = $signed({1'b0, s4_logd_reg}) - $signed({1'b0, s4_logr_reg});
        s5_abs_next = s5_l[21] ? 21'(-s5_l) : s5_l[20:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_abs_reg    <= s5_abs_next;
            s5_neg_reg    <= s5_l[21];
            s5_status_reg <= s4_status_reg;
            s5_d_reg      <= s4_d_reg;
            s5_pc0_reg    <= s4_pc0_reg;
            s5_n_reg      <= s4_n_reg;
        end
    end

    // stage 6: scale by the exponent, q4.12 times q16
    logic [36:0]       s6_prod;
    logic [24:0]       s6_mag_reg;
    logic              s6_neg_reg;
    plcp_pkg::status_t s6_status_reg;
    logic [15:0]       s6_d_reg;
    logic [31:0]       s6_pc0_reg;
    logic [15:0]       s6_n_reg;

    assign s6_prod = 37'(s5_n_reg) * 37'(s5_abs_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_mag_reg    <= s6_prod[36:12];
            s6_neg_reg    <= s5_neg_reg;
            s6_status_reg <= s5_status_reg;
            s6_d_reg      <= s5_d_reg;
            s6_pc0_reg    <= s5_pc0_reg;
            s6_n_reg      <= s5_n_reg;
        end
    end

    // stage 7: power exponent into integer part and fraction (floor toward minus infinity)
    logic signed [10:0]   s7_ip_next, s7_ip_reg;
    logic [15:0]          s7_fp;
    logic [IDX_W-1:0]     s7_idx_reg;
    logic [EXP_REM_W-1:0] s7_rem_reg;
    plcp_pkg::status_t    s7_status_reg;
    logic [15:0]          s7_d_reg;
    logic [31:0]          s7_pc0_reg;
    logic [15:0]          s7_n_reg;

    always_comb
    begin
        if (s6_neg_reg)
        begin
            // snorm below one, pressure above pc0
            s7_ip_next = $signed(11'(s6_mag_reg[24:16]));
            s7_fp      = s6_mag_reg[15:0];
        end
        else
        begin
            s7_ip_next = -$signed(11'(s6_mag_reg[24:16]) + 11'(s6_mag_reg[15:0] != 16'd0));
            s7_fp      = 16'd0 - s6_mag_reg[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_ip_reg     <= s7_ip_next;
            s7_idx_reg    <= s7_fp[15 -: IDX_W];
            s7_rem_reg    <= s7_fp[EXP_REM_W-1:0];
            s7_status_reg <= s6_status_reg;
            s7_d_reg      <= s6_d_reg;
            s7_pc0_reg    <= s6_pc0_reg;
            s7_n_reg      <= s6_n_reg;
        end
    end

    // stage 8: exp table reads
    logic [31:0]          s8_lo_next, s8_lo_reg, s8_df_reg;
    logic signed [10:0]   s8_ip_reg;
    logic [EXP_REM_W-1:0] s8_rem_reg;
    plcp_pkg::status_t    s8_status_reg;
    logic [15:0]          s8_d_reg;
    logic [31:0]          s8_pc0_reg;
    logic [15:0]          s8_n_reg;

    assign s8_lo_next = EXP_ROM[{1'b0, s7_idx_reg}];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s8_lo_reg     <= s8_lo_next;
            s8_df_reg     <= EXP_ROM[(IDX_W+1)'(s7_idx_reg) + 1'b1] - s8_lo_next;
            s8_ip_reg     <= s7_ip_reg;
            s8_rem_reg    <= s7_rem_reg;
            s8_status_reg <= s7_status_reg;
            s8_d_reg      <= s7_d_reg;
            s8_pc0_reg    <= s7_pc0_reg;
            s8_n_reg      <= s7_n_reg;
        end
    end

    // stage 9: interpolated mantissa, q1.30
    logic [32+EXP_REM_W-1:0] s9_prod;
    logic [31:0]             s9_mant_reg;
    logic signed [10:0]      s9_ip_reg;
    plcp_pkg::status_t       s9_status_reg;
    logic [15:0]             s9_d_reg;
    logic [31:0]             s9_pc0_reg;
    logic [15:0]             s9_n_reg;

    assign s9_prod = (32+EXP_REM_W)'(s8_df_reg) * (32+EXP_REM_W)'(s8_rem_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s9_mant_reg   <= s8_lo_reg + 32'(s9_prod >> EXP_REM_W);
            s9_ip_reg     <= s8_ip_reg;
            s9_status_reg <= s8_status_reg;
            s9_d_reg      <= s8_d_reg;
            s9_pc0_reg    <= s8_pc0_reg;
            s9_n_reg      <= s8_n_reg;
        end
    end

    // stage 10: pc0 times mantissa
    logic [63:0]        s10_p_reg;
    logic signed [10:0] s10_ip_reg;
    plcp_pkg::status_t  s10_status_reg;
    logic [15:0]        s10_d_reg;
    logic [15:0]        s10_n_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s10_p_reg      <= 64'(s9_pc0_reg) * 64'(s9_mant_reg);
            s10_ip_reg     <= s9_ip_reg;
            s10_status_reg <= s9_status_reg;
            s10_d_reg      <= s9_d_reg;
            s10_n_reg      <= s9_n_reg;
        end
    end

    // stage 11: apply 2^ip, drop the q30 scale, clamp the wide pressure at 2^62
    logic signed [10:0] s11_sh;
    logic [10:0]        s11_nsh;
    logic [63:0]        s11_lim;
    logic [63:0]        s11_w;
    logic [62:0]        s11_w_reg;
    logic [31:0]        s11_cap_next, s11_cap_reg;
    plcp_pkg::status_t  s11_status_reg;
    logic [15:0]        s11_d_reg;
    logic [15:0]        s11_n_reg;

    always_comb
    begin
        s11_sh  = s10_ip_reg - 11'sd30;
        s11_nsh = 11'(-s11_sh);
        s11_lim = plcp_pkg::WIDE_CAP >> s11_sh[5:0];
        if (s10_p_reg == 64'd0)
            s11_w = '0;
        else if (!s11_sh[10])
        begin
            if (s11_sh >= 11'sd62 || s10_p_reg > s11_lim)
                s11_w = plcp_pkg::WIDE_CAP;
            else
                s11_w = s10_p_reg << s11_sh[5:0];
        end
        else if (s11_nsh >= 11'd64)
            s11_w = '0;
        else
            s11_w = s10_p_reg >> s11_nsh[5:0];
        if (s11_w > plcp_pkg::WIDE_CAP)
            s11_w = plcp_pkg::WIDE_CAP;
        s11_cap_next = (s11_w[63:32] != 32'd0) ? 32'hFFFF_FFFF : s11_w[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s11_w_reg      <= s11_w[62:0];
            s11_cap_reg    <= s11_cap_next;
            s11_status_reg <= s10_status_reg;
            s11_d_reg      <= s10_d_reg;
            s11_n_reg      <= s10_n_reg;
        end
    end

    // stage 12: slope numerator 8n*W as two partial products
    logic [18:0]       s12_a;
    logic [50:0]       s12_plo_reg;
    logic [49:0]       s12_phi_reg;
    logic [31:0]       s12_cap_reg;
    plcp_pkg::status_t s12_status_reg;
    logic [15:0]       s12_d_reg;

    assign s12_a = {s11_n_reg, 3'b000};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s12_plo_reg    <= 51'(s12_a) * 51'(s11_w_reg[31:0]);
            s12_phi_reg    <= 50'(s12_a) * 50'(s11_w_reg[62:32]);
            s12_cap_reg    <= s11_cap_reg;
            s12_status_reg <= s11_status_reg;
            s12_d_reg      <= s11_d_reg;
        end
    end

    // stage 13: sum partials; quotient saturates when numerator reaches d * 2^47
    logic [81:0]       s13_num;
    logic [62:0]       s13_num_reg;
    logic              s13_sat_reg;
    logic [31:0]       s13_cap_reg;
    plcp_pkg::status_t s13_status_reg;
    logic [15:0]       s13_d_reg;

    assign s13_num = (82'(s12_phi_reg) << 32) + 82'(s12_plo_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s13_num_reg    <= s13_num[62:0];
            s13_sat_reg    <= s13_num >= (82'(s12_d_reg) << plcp_pkg::SLOPE_Q_W);
            s13_cap_reg    <= s12_cap_reg;
            s13_status_reg <= s12_status_reg;
            s13_d_reg      <= s12_d_reg;
        end
    end

    // divider: slope magnitude = 8n*W / d, up to four quotient bits per stage
    logic [plcp_pkg::SLOPE_Q_W-1:0] quot;

    plcp_div #(
        .QW    (plcp_pkg::SLOPE_Q_W),
        .DW    (16),
        .STEPS (plcp_pkg::DIV_STEPS)
    ) u_div (
        .clk    (clk),
        .en     (en),
        .rem_in (s13_num_reg[62 -: 16]),
        .num_in (s13_num_reg[plcp_pkg::SLOPE_Q_W-1:0]),
        .den_in (s13_d_reg),
        .quot   (quot)
    );

    // side band matched to the divider latency
    logic [31:0]       dly_cap_reg    [0:DIV_ST-1];
    plcp_pkg::status_t dly_status_reg [0:DIV_ST-1];
    logic              dly_sat_reg    [0:DIV_ST-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_cap_reg[0]    <= s13_cap_reg;
            dly_status_reg[0] <= s13_status_reg;
            dly_sat_reg[0]    <= s13_sat_reg;
            for (int i = 1; i < DIV_ST; i++)
            begin
                dly_cap_reg[i]    <= dly_cap_reg[i-1];
                dly_status_reg[i] <= dly_status_reg[i-1];
                dly_sat_reg[i]    <= dly_sat_reg[i-1];
            end
        end
    end

    // output register: negate the slope, zero both values on a flagged cell
    logic [47:0]       slope_mag;
    plcp_pkg::result_t result_next, result_reg;

    always_comb
    begin
        slope_mag = dly_sat_reg[DIV_ST-1] ? (48'd1 << plcp_pkg::SLOPE_Q_W)
                                          : 48'(quot);
        result_next.status = dly_status_reg[DIV_ST-1];
        if (dly_status_reg[DIV_ST-1] == plcp_pkg::STATUS_OK)
        begin
            result_next.cap_pressure       = dly_cap_reg[DIV_ST-1];
            result_next.cap_pressure_slope = $signed(48'd0 - slope_mag);
        end
        else
        begin
            result_next.cap_pressure       = '0;
            result_next.cap_pressure_slope = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            result_reg <= result_next;
    end

    assign result_valid = out_vld_reg;
    assign result       = result_reg;

    // a flagged cell carries no pressure and no slope
    `PLCP_ASSERT_SAME(a_flag_zero, result_valid && result.status != plcp_pkg::STATUS_OK,
        result.cap_pressure == 32'd0 && result.cap_pressure_slope == 48'sd0)
    // the slope is never positive
    `PLCP_ASSERT_SAME(a_slope_sign, result_valid,
        result.cap_pressure_slope[47] || result.cap_pressure_slope == 48'sd0)
    // a nonzero slope needs a nonzero pressure
    `PLCP_ASSERT_SAME(a_slope_pressure, result_valid && result.cap_pressure_slope != 48'sd0,
        result.cap_pressure != 32'd0)
    // a held result keeps the front of the pipeline frozen
    `PLCP_ASSERT_NEXT(a_stall_freeze, result_valid && !result_ready && vld_reg[0],
        vld_reg[0] && $stable(s1_d_reg))

endmodule

`default_nettype wire
